@@ sv/hst_pkg.sv @@
// Shared types and codes for the handle slot table.
// No dependencies; imported by hst_slot_ram and handle_slot_table.
package hst_pkg;

	localparam int HANDLE_W = 32;
	localparam int CTX_W    = 16;

	// request kinds carried on s_tuser
	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_RETIRE   = 2'd1;
	localparam logic [1:0] REQ_GRAB     = 2'd2;

	// result status carried on m_tuser
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef struct packed {
		logic                valid;
		logic [CTX_W-1:0]    ctx;
		logic [HANDLE_W-1:0] hnd;
	} slot_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK
	} state_t;

	// next handle in sequence, skipping zero on wrap
	function automatic logic [HANDLE_W-1:0] bump(input logic [HANDLE_W-1:0] h);
		logic [HANDLE_W-1:0] n;
		n = h + HANDLE_W'(1);
		return (n == '0) ? HANDLE_W'(1) : n;
	endfunction

endpackage

@@ sv/hst_slot_ram.sv @@
// Slot store: one write port and one read port with registered read data.
// Depends on hst_pkg for the slot entry type.
module hst_slot_ram #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  hst_pkg::slot_t           wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output hst_pkg::slot_t           rdata
);
	import hst_pkg::*;

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/handle_slot_table.sv @@
// Handle slot table: register, retire and grab of handles by linear probing.
// Retire, grab and unknown requests: slot read at acceptance, result registered from
// the check state once the output is free. Register: one probe per occupied slot;
// the single slot RAM read port sets the pace. No new beat until the result is loaded.
// After reset the slot RAM is swept empty, one slot at a time, with s_tready low.
// Depends on hst_pkg and hst_slot_ram.
module handle_slot_table #(
	parameter int SLOTS = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // [31:0] req_handle, [47:32] context_id
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [31:0] new_handle, [47:32] found_context
	output logic [1:0]  m_tuser   // [1:0] status
);
	import hst_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);

	state_t                state_q, state_d;
	logic [IDX_W-1:0]      clr_q;
	logic [1:0]            type_q;
	logic [HANDLE_W-1:0]   hdl_q;
	logic [CTX_W-1:0]      ctx_q;
	logic [HANDLE_W-1:0]   cand_q;
	logic [HANDLE_W-1:0]   cand_next;
	logic [HANDLE_W-1:0]   next_handle_q;
	logic [CNT_W-1:0]      used_q;

	logic                  m_tvalid_q;
	logic [47:0]           m_tdata_q;
	logic [1:0]            m_tuser_q;

	logic                  mem_we, mem_re;
	logic [IDX_W-1:0]      mem_waddr, mem_raddr;
	slot_t                 mem_wdata, mem_rdata;

	logic                  out_free, hit, accept;
	logic                  res_load, cand_adv, used_inc, used_dec;
	logic [1:0]            res_status;
	logic [HANDLE_W-1:0]   res_handle;
	logic [CTX_W-1:0]      res_ctx;

	hst_slot_ram #(
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cand_next = bump(cand_q);
	assign hit       = mem_rdata.valid && (mem_rdata.hnd == hdl_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = hdl_q[IDX_W-1:0];
		mem_wdata  = '0;
		mem_re     = 1'b0;
		mem_raddr  = cand_next[IDX_W-1:0];
		res_load   = 1'b0;
		res_status = STAT_NOT_FOUND;
		res_handle = '0;
		res_ctx    = '0;
		cand_adv   = 1'b0;
		used_inc   = 1'b0;
		used_dec   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == IDX_LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					mem_re    = 1'b1;
					mem_raddr = (s_tuser == REQ_REGISTER) ? next_handle_q[IDX_W-1:0]
					                                      : s_tdata[IDX_W-1:0];
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (type_q)
					REQ_REGISTER: begin
						if (used_q == CNT_FULL) begin
							if (out_free) begin
								res_load   = 1'b1;
								res_status = STAT_FULL;
								state_d    = S_IDLE;
							end
						end else if (mem_rdata.valid) begin
							// slot taken: advance to the next candidate
							cand_adv = 1'b1;
							mem_re   = 1'b1;
						end else if (out_free) begin
							mem_we     = 1'b1;
							mem_waddr  = cand_q[IDX_W-1:0];
							mem_wdata  = '{valid: 1'b1, ctx: ctx_q, hnd: cand_q};
							res_load   = 1'b1;
							res_status = STAT_OK;
							res_handle = cand_q;
							used_inc   = 1'b1;
							state_d    = S_IDLE;
						end
					end
					REQ_RETIRE, REQ_GRAB: begin
						if (out_free) begin
							res_load = 1'b1;
							state_d  = S_IDLE;
							if (hit) begin
								res_status = STAT_OK;
								if (type_q == REQ_RETIRE) begin
									mem_we   = 1'b1;
									used_dec = 1'b1;
								end else begin
									res_ctx = mem_rdata.ctx;
								end
							end
						end
					end
					default: begin
						if (out_free) begin
							res_load = 1'b1;
							state_d  = S_IDLE;
						end
					end
				endcase
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q         <= '0;
			next_handle_q <= HANDLE_W'(1);
			used_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (used_inc) begin
				used_q        <= used_q + CNT_W'(1);
				next_handle_q <= cand_next;
			end else if (used_dec && used_q != '0) begin
				used_q <= used_q - CNT_W'(1);
			end
			if (res_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= s_tuser;
			hdl_q  <= s_tdata[31:0];
			ctx_q  <= s_tdata[47:32];
			cand_q <= next_handle_q;
		end else if (cand_adv) begin
			cand_q <= cand_next;
		end
		if (res_load) begin
			m_tdata_q <= {res_ctx, res_handle};
			m_tuser_q <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_FULL)
		else $error("used count above table size");

	a_handle_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_handle_q != '0)
		else $error("handle counter reached zero");

	a_register_count: assert property (@(posedge clk) disable iff (!arst_n)
		used_inc |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("register did not bump used count");

	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && type_q == REQ_REGISTER && used_q == CNT_FULL) |-> !mem_we)
		else $error("slot written while table full");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for handle_slot_table: random register/retire/grab traffic with a built-in
// slot table predictor and in-order checking of every result beat.
// Depends on hst_pkg and handle_slot_table.
module tb_top;
	import hst_pkg::*;

	localparam int SLOTS = 256;
	localparam logic [HANDLE_W-1:0] IDX_MASK = HANDLE_W'(SLOTS - 1);
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int QUEUE_AHEAD = 4;

	typedef struct packed {
		logic [1:0]          kind;
		logic [HANDLE_W-1:0] hnd;
		logic [CTX_W-1:0]    ctx;
	} request_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [HANDLE_W-1:0] new_hnd;
		logic [CTX_W-1:0]    ctx;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // [31:0] req_handle, [47:32] context_id
	logic [1:0]  s_tuser = '0;   // [1:0] req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // [31:0] new_handle, [47:32] found_context
	logic [1:0]  m_tuser;        // [1:0] status

	handle_slot_table #(.SLOTS(SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// predicted table contents
	bit                  slot_valid [SLOTS];
	logic [CTX_W-1:0]    slot_ctx   [SLOTS];
	logic [HANDLE_W-1:0] slot_hnd   [SLOTS];
	logic [HANDLE_W-1:0] next_hnd = HANDLE_W'(1);
	int                  used_cnt = 0;
	logic [HANDLE_W-1:0] live_hnd [$];

	request_t request_q [$];
	answer_t  answer_q [$];
	int       errors = 0;
	int       cycle_cnt = 0;
	bit       beat_taken = 1'b0;
	bit       tx_hold = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       stall_left = 0;
	int       mode_left = 0;
	int       ready_mode = 0;
	request_t drive_req;
	answer_t  want;

	function automatic logic [HANDLE_W-1:0] handle_after(input logic [HANDLE_W-1:0] h);
		logic [HANDLE_W-1:0] n;
		n = h + HANDLE_W'(1);
		if (n == '0)
			n = HANDLE_W'(1);
		return n;
	endfunction

	// update the predicted table with one request and return its result
	function automatic answer_t apply_request(input request_t r);
		answer_t             a;
		logic [HANDLE_W-1:0] cand;
		int                  idx;
		int                  probe;
		int                  k;
		bit                  placed;
		a = '{status: STAT_NOT_FOUND, new_hnd: '0, ctx: '0};
		placed = 1'b0;
		case (r.kind)
			REQ_REGISTER: begin
				a.status = STAT_FULL;
				if (used_cnt < SLOTS) begin
					cand = (next_hnd == '0) ? HANDLE_W'(1) : next_hnd;
					for (probe = 0; probe <= SLOTS && !placed; probe++) begin
						idx = int'(cand & IDX_MASK);
						if (!slot_valid[idx]) begin
							slot_valid[idx] = 1'b1;
							slot_ctx[idx] = r.ctx;
							slot_hnd[idx] = cand;
							used_cnt++;
							next_hnd = handle_after(cand);
							live_hnd.push_back(cand);
							a.status = STAT_OK;
							a.new_hnd = cand;
							placed = 1'b1;
						end else begin
							cand = handle_after(cand);
						end
					end
				end
			end
			REQ_RETIRE, REQ_GRAB: begin
				idx = int'(r.hnd & IDX_MASK);
				if (slot_valid[idx] && slot_hnd[idx] == r.hnd) begin
					a.status = STAT_OK;
					if (r.kind == REQ_GRAB) begin
						a.ctx = slot_ctx[idx];
					end else begin
						slot_valid[idx] = 1'b0;
						slot_ctx[idx] = '0;
						slot_hnd[idx] = '0;
						if (used_cnt > 0)
							used_cnt--;
						k = 0;
						while (k < live_hnd.size()) begin
							if (live_hnd[k] == r.hnd)
								live_hnd.delete(k);
							else
								k++;
						end
					end
				end
			end
			default: begin
			end
		endcase
		return a;
	endfunction

	task automatic report(input string what, input logic [HANDLE_W-1:0] got,
			input logic [HANDLE_W-1:0] exp_val);
		if (errors < 50)
			$display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, exp_val);
		errors++;
	endtask

	task automatic enqueue(input logic [1:0] kind, input logic [HANDLE_W-1:0] hnd,
			input logic [CTX_W-1:0] ctx);
		request_t r;
		r = '{kind: kind, hnd: hnd, ctx: ctx};
		while (request_q.size() >= QUEUE_AHEAD)
			@(posedge clk);
		request_q.push_back(r);
	endtask

	// mostly live handles, some aimed at the same slot with a different handle
	function automatic logic [HANDLE_W-1:0] pick_handle();
		logic [HANDLE_W-1:0] h;
		if (live_hnd.size() > 0 && $urandom_range(0, 7) != 0) begin
			h = live_hnd[$urandom_range(0, live_hnd.size() - 1)];
			if ($urandom_range(0, 5) == 0)
				h = h ^ (HANDLE_W'(SLOTS) << $urandom_range(0, 23));
		end else begin
			h = $urandom();
		end
		return h;
	endfunction

	task automatic send_mix(input int count, input int reg_pct, input int ret_pct,
			input int grab_pct);
		int                  n;
		int                  w;
		logic [CTX_W-1:0]    ctx;
		logic [HANDLE_W-1:0] h;
		for (n = 0; n < count; n++) begin
			w = $urandom_range(0, 99);
			ctx = CTX_W'($urandom_range(0, 65535));
			h = $urandom();
			if (w < reg_pct)
				enqueue(REQ_REGISTER, h, ctx);
			else if (w < reg_pct + ret_pct)
				enqueue(REQ_RETIRE, pick_handle(), ctx);
			else if (w < reg_pct + ret_pct + grab_pct)
				enqueue(REQ_GRAB, pick_handle(), ctx);
			else if ($urandom_range(0, 1) == 0)
				enqueue(REQ_UNKNOWN, h, ctx);
			else
				enqueue(($urandom_range(0, 1) == 0) ? REQ_RETIRE : REQ_GRAB, h, ctx);
		end
	endtask

	// sender: bursts of beats separated by idle gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || beat_taken) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (burst_left > 0) begin
					if (request_q.size() > 0 && !tx_hold) begin
						drive_req = request_q.pop_front();
						s_tdata <= {drive_req.ctx, drive_req.hnd};
						s_tuser <= drive_req.kind;
						s_tvalid <= 1'b1;
						burst_left--;
					end else begin
						s_tvalid <= 1'b0;
					end
				end else begin
					gap_left--;
					s_tvalid <= 1'b0;
				end
			end
			beat_taken = 1'b0;
		end
	end

	// receiver: stall pattern changes every so often; long hold-off on request
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 200);
			end else begin
				mode_left--;
			end
			case (ready_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// predict on each accepted request beat, then check each result beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				answer_q.push_back(apply_request('{kind: s_tuser, hnd: s_tdata[31:0],
					ctx: s_tdata[47:32]}));
				beat_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (answer_q.size() == 0) begin
					report("unexpected result beat", m_tdata[31:0], '0);
				end else begin
					want = answer_q.pop_front();
					if (m_tuser !== want.status)
						report("status", HANDLE_W'(m_tuser), HANDLE_W'(want.status));
					if (m_tdata[31:0] !== want.new_hnd)
						report("new_handle", m_tdata[31:0], want.new_hnd);
					if (m_tdata[47:32] !== want.ctx)
						report("found_context", HANDLE_W'(m_tdata[47:32]), HANDLE_W'(want.ctx));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: first handles come out as 1, 2, 3 ...
		enqueue(REQ_REGISTER, 32'hFFFF_FFFF, 16'h0000);
		enqueue(REQ_REGISTER, 32'h0000_0000, 16'hFFFF);
		enqueue(REQ_GRAB, 32'd1, 16'h0000);
		enqueue(REQ_GRAB, 32'd2, 16'hFFFF);
		enqueue(REQ_GRAB, 32'h0000_0101, 16'h0000);
		enqueue(REQ_GRAB, 32'h8000_0002, 16'h0000);
		enqueue(REQ_RETIRE, 32'h0000_0101, 16'h0000);
		enqueue(REQ_RETIRE, 32'd1, 16'h0000);
		enqueue(REQ_GRAB, 32'd1, 16'h0000);
		enqueue(REQ_RETIRE, 32'd1, 16'h0000);
		enqueue(REQ_GRAB, 32'd0, 16'h0000);
		enqueue(REQ_RETIRE, 32'd0, 16'h0000);
		enqueue(REQ_GRAB, 32'hFFFF_FFFF, 16'hFFFF);
		enqueue(REQ_RETIRE, 32'hFFFF_FFFF, 16'hFFFF);
		enqueue(REQ_UNKNOWN, 32'd2, 16'hFFFF);
		enqueue(REQ_REGISTER, 32'd2, 16'h8001);
		enqueue(REQ_GRAB, 32'd3, 16'hFFFF);
		enqueue(REQ_REGISTER, 32'd0, 16'h7FFE);

		send_mix(100, 45, 20, 25);
		// hold off the result side while requests keep coming
		stall_left = 1000;
		send_mix(200, 45, 20, 25);
		// fill the table and keep registering past full
		send_mix(280, 100, 0, 0);
		send_mix(150, 10, 50, 35);

		// hold the sender and let the results drain before the next phase
		tx_hold = 1'b1;
		while (s_tvalid || answer_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		tx_hold = 1'b0;

		send_mix(250, 60, 10, 25);
		send_mix(500, 35, 30, 25);

		while (request_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (SLOTS + 16) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
